>>> src/mctt_pkg.sv
package mctt_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_REGISTER = 2'd1,
    KIND_START    = 2'd2,
    KIND_STOP     = 2'd3
  } kind_t;

  localparam int SLOT_FIELD_W = 3;
  localparam int MASK_W       = 8;
  localparam int PERIOD_W     = 32;

  // command item
  typedef struct packed {
    kind_t                     kind;
    logic [PERIOD_W-1:0]       period_ticks;
    logic                      one_shot;
    logic [SLOT_FIELD_W-1:0]   slot;
  } cmd_item_t;

  // result item
  typedef struct packed {
    logic [SLOT_FIELD_W-1:0]   assigned_slot;
    logic                      failed;
    logic [MASK_W-1:0]         fired_mask;
  } res_item_t;

endpackage

>>> src/multi_channel_tick_timer.sv
// Multi-channel tick timer: NUM_SLOTS virtual timers driven by tick items.
// A register item claims the lowest free slot (returns failed on a zero period
// or a full table), start arms a registered slot with its full period, stop
// frees it, and each tick counts every armed slot down and reports in
// fired_mask the slots that expired; periodic slots reload, single-shot slots
// free themselves. Every command item gives exactly one result item. The block
// takes one item per cycle unless a stalled result holds it back; an accepted
// item passes through the input register, then the result register, and all
// slots update in parallel as it moves into the result register. Only slots
// 0 to 7 can be addressed or reported.
module multi_channel_tick_timer
  import mctt_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  // input register
  logic      stage_valid;
  cmd_item_t stage;
  logic      advance;

  assign advance   = stage_valid && (!res_valid || res_ready);
  assign cmd_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd_ready) begin
      stage_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      stage <= cmd;
    end
  end

  // slot state
  logic [PERIOD_W-1:0] slot_period    [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_remaining [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_in_use;
  logic [NUM_SLOTS-1:0] slot_armed;
  logic [NUM_SLOTS-1:0] slot_one_shot;

  logic [PERIOD_W-1:0] slot_period_next    [NUM_SLOTS];
  logic [PERIOD_W-1:0] slot_remaining_next [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_in_use_next;
  logic [NUM_SLOTS-1:0] slot_armed_next;
  logic [NUM_SLOTS-1:0] slot_one_shot_next;

  res_item_t res_next;

  // slot update and result for the staged item
  always_comb begin
    logic [NUM_SLOTS-1:0] fired;
    logic                 found;
    logic [PERIOD_W-1:0]  dec;
    logic                 hit;

    slot_period_next    = slot_period;
    slot_remaining_next = slot_remaining;
    slot_in_use_next    = slot_in_use;
    slot_armed_next     = slot_armed;
    slot_one_shot_next  = slot_one_shot;
    fired               = '0;
    found               = 1'b0;
    dec                 = '0;
    hit                 = 1'b0;
    res_next            = '0;

    unique case (stage.kind)
      KIND_TICK: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (slot_armed[s]) begin
            dec = (slot_remaining[s] != '0) ? slot_remaining[s] - 1'b1 : '0;
            slot_remaining_next[s] = dec;
            if (dec == '0) begin
              fired[s] = 1'b1;
              if (slot_one_shot[s]) begin
                slot_period_next[s]    = '0;
                slot_remaining_next[s] = '0;
                slot_in_use_next[s]    = 1'b0;
                slot_armed_next[s]     = 1'b0;
                slot_one_shot_next[s]  = 1'b0;
              end else begin
                slot_remaining_next[s] = slot_period[s];
              end
            end
          end
        end
      end
      KIND_REGISTER: begin
        // lowest free slot wins
        if (stage.period_ticks != '0) begin
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (!found && !slot_in_use[s]) begin
              found                  = 1'b1;
              slot_in_use_next[s]    = 1'b1;
              slot_armed_next[s]     = 1'b0;
              slot_one_shot_next[s]  = stage.one_shot;
              slot_period_next[s]    = stage.period_ticks;
              slot_remaining_next[s] = stage.period_ticks;
              res_next.assigned_slot = SLOT_FIELD_W'(s);
            end
          end
        end
        if (!found) begin
          res_next.failed        = 1'b1;
          res_next.assigned_slot = '0;
        end
      end
      KIND_START: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          hit = (32'(stage.slot) == 32'(s));
          if (hit && slot_in_use[s]) begin
            slot_armed_next[s]     = 1'b1;
            slot_remaining_next[s] = slot_period[s];
          end
        end
      end
      KIND_STOP: begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          hit = (32'(stage.slot) == 32'(s));
          if (hit && slot_in_use[s]) begin
            slot_period_next[s]    = '0;
            slot_remaining_next[s] = '0;
            slot_in_use_next[s]    = 1'b0;
            slot_armed_next[s]     = 1'b0;
            slot_one_shot_next[s]  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    // only the low slots show in the mask
    for (int i = 0; i < MASK_W; i++) begin
      if (i < NUM_SLOTS) begin
        res_next.fired_mask[i] = fired[i];
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_in_use   <= '0;
      slot_armed    <= '0;
      slot_one_shot <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_period[s]    <= '0;
        slot_remaining[s] <= '0;
      end
    end else if (advance) begin
      slot_in_use    <= slot_in_use_next;
      slot_armed     <= slot_armed_next;
      slot_one_shot  <= slot_one_shot_next;
      slot_period    <= slot_period_next;
      slot_remaining <= slot_remaining_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule

>>> src/mctt_checker.sv
module mctt_checker
  import mctt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_ready,
  input cmd_item_t cmd,
  input logic      res_valid,
  input logic      res_ready,
  input res_item_t res
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // a failed register never reports a slot
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.failed |-> res.assigned_slot == '0)
    else $error("failed result carries a slot");

  // a tick result carries no register outcome
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.fired_mask != '0 |-> !res.failed && res.assigned_slot == '0)
    else $error("fired mask mixed with register outcome");

  // with no result pending the block takes a new item
  assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("input stalled with empty output");

endmodule

bind multi_channel_tick_timer mctt_checker u_mctt_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .cmd       (cmd),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
